[rtl/site_pattern_dedup_counter_core_assert.svh]
// Assertion macros for the checker file of the site pattern dedup core.
// No dependencies; take in with `include before use.
`ifndef SITE_PATTERN_DEDUP_COUNTER_CORE_ASSERT_SVH
`define SITE_PATTERN_DEDUP_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SPDC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("site pattern core: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define SPDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("site pattern core: next-cycle check failed");

`endif

[rtl/spdc_pkg.sv]
// Types, constants and helper functions of the site pattern dedup core.
// No dependencies; imported by the top level, spdc_ctrl and spdc_checker.
`default_nettype none

package spdc_pkg;

	localparam int MAX_TAXA     = 16;
	localparam int MAX_PATTERNS = 256;
	localparam int COUNT_W      = 16;

	localparam int TAXA_W  = 5;
	localparam int COL_W   = 4 * MAX_TAXA;
	localparam int IDX_W   = $clog2(MAX_PATTERNS);
	localparam int TOTAL_W = IDX_W + 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_FULL = TOTAL_W'(MAX_PATTERNS);

	// Command codes
	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_ADD   = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]       func;
		logic [COL_W-1:0] site_column;
		logic [IDX_W-1:0] pattern_select;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]   pattern_index;
		logic               is_new;
		logic               table_full;
		logic [COL_W-1:0]   pattern_column;
		logic [COUNT_W-1:0] pattern_sites;
		logic [TOTAL_W-1:0] total_patterns;
	} rsp_t;

	// One table entry as held in memory
	typedef struct packed {
		logic [COUNT_W-1:0] sites;
		logic [COL_W-1:0]   column;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Memory request from the sequencer
	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   waddr;
		entry_t             wdata;
		logic               re;
		logic [IDX_W-1:0]   raddr;
	} mem_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ
	} state_t;

	// Mask of the code slots in use; zero taxa acts as one, too many as all
	function automatic logic [COL_W-1:0] taxa_mask(input logic [TAXA_W-1:0] n);
		logic [TAXA_W-1:0] eff;
		logic [COL_W-1:0]  m;
		eff = n;
		if (n == '0) begin
			eff = TAXA_W'(1);
		end else if (n > TAXA_W'(MAX_TAXA)) begin
			eff = TAXA_W'(MAX_TAXA);
		end
		for (int i = 0; i < MAX_TAXA; i++) begin
			m[4*i +: 4] = (TAXA_W'(i) < eff) ? 4'hF : 4'h0;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

[rtl/site_pattern_dedup_counter_core.sv]
// Channel      | Signals                         | Transfer
// -------------+---------------------------------+-------------------------------
// command      | start, busy, req                | clk edge with start & !busy
// result       | done, result                    | clk edge ending the done cycle
// config       | cfg_we, cfg_wdata (num_taxa)    | clk edge with cfg_we
//
// A clear, an unused command or an add to an empty table is answered without
// raising busy; a read of a stored pattern passes through ST_READ. An add reads
// the pattern memory once a cycle from entry 0 and stops at the first match, or
// at the last stored entry when the pattern is new. The result shows for one
// cycle, after the last busy cycle or after the command if busy stays low.
// Reset empties the table at once; memory contents are never cleared.
// The receiver cannot stall; busy alone holds off new commands.
// Uses spdc_pkg, spdc_ctrl and spdc_ram.
`default_nettype none

module site_pattern_dedup_counter_core import spdc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire req_t              req,
	output logic                   busy,
	output logic                   done,
	output rsp_t                   result,
	input  wire logic              cfg_we,
	input  wire logic [TAXA_W-1:0] cfg_wdata
);

	logic [TAXA_W-1:0]  num_taxa_q;
	logic [COL_W-1:0]   mask;
	mem_req_t           mem;
	logic [ENTRY_W-1:0] rd_data;

	// Taxon count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_taxa_q <= TAXA_W'(MAX_TAXA);
		end else if (cfg_we) begin
			num_taxa_q <= cfg_wdata;
		end
	end

	assign mask = taxa_mask(num_taxa_q);

	// Sequencer
	spdc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.mask    (mask),
		.rd_data (rd_data),
		.mem     (mem),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	// Pattern table: column and site count per entry
	spdc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_PATTERNS)
	) u_table (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (rd_data)
	);

endmodule

`default_nettype wire

[rtl/spdc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module spdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/spdc_ctrl.sv]
// Command sequencer of the site pattern dedup core: clears the table, scans the
// pattern memory, updates counts, appends patterns, reads entries and builds the result. Uses spdc_pkg.
`default_nettype none

module spdc_ctrl import spdc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire req_t             req,
	input  wire logic [COL_W-1:0] mask,
	input  wire logic [ENTRY_W-1:0] rd_data,
	output mem_req_t              mem,
	output logic                  busy,
	output logic                  done,
	output rsp_t                  result
);

	state_t             state_q, state_d;
	logic [COL_W-1:0]   col_q, col_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic [TOTAL_W-1:0] total_q, total_d;
	logic               done_q, done_d;
	rsp_t               result_q, result_d;

	entry_t             rd_entry;
	logic [COL_W-1:0]   col_in;
	logic               sel_valid;
	logic               hit;
	logic               last;
	logic [COUNT_W-1:0] cnt_inc;

	assign rd_entry  = entry_t'(rd_data);
	assign col_in    = req.site_column & mask;
	assign sel_valid = {1'b0, req.pattern_select} < total_q;
	assign hit       = ((rd_entry.column ^ col_q) & mask) == '0;
	assign last      = {1'b0, idx_q} == (total_q - TOTAL_W'(1));
	assign cnt_inc   = (rd_entry.sites == COUNT_MAX) ? rd_entry.sites
	                                                 : rd_entry.sites + COUNT_W'(1);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && req.func == FUNC_ADD && total_q != '0) begin
					state_d = ST_SCAN;
				end else if (start && req.func == FUNC_READ && sel_valid) begin
					state_d = ST_READ;
				end
			end
			ST_SCAN: begin
				if (hit || last) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory requests, result and table bookkeeping
	always_comb begin
		mem      = '0;
		col_d    = col_q;
		idx_d    = idx_q;
		total_d  = total_q;
		done_d   = 1'b0;
		result_d = '0;
		result_d.total_patterns = total_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (req.func)
						FUNC_CLEAR: begin
							total_d  = '0;
							done_d   = 1'b1;
							result_d = '0;
						end
						FUNC_ADD: begin
							col_d = col_in;
							if (total_q == '0) begin
								// empty table: store as first pattern
								mem.we           = 1'b1;
								mem.waddr        = '0;
								mem.wdata.column = col_in;
								mem.wdata.sites  = COUNT_W'(1);
								total_d          = TOTAL_W'(1);
								done_d           = 1'b1;
								result_d.is_new         = 1'b1;
								result_d.pattern_column = col_in;
								result_d.pattern_sites  = COUNT_W'(1);
								result_d.total_patterns = TOTAL_W'(1);
							end else begin
								mem.re    = 1'b1;
								mem.raddr = '0;
								idx_d     = '0;
							end
						end
						FUNC_READ: begin
							result_d.pattern_index = req.pattern_select;
							if (sel_valid) begin
								mem.re    = 1'b1;
								mem.raddr = req.pattern_select;
								idx_d     = req.pattern_select;
							end else begin
								done_d = 1'b1;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (hit) begin
					// bump the matching pattern's count
					mem.we           = 1'b1;
					mem.waddr        = idx_q;
					mem.wdata.column = rd_entry.column;
					mem.wdata.sites  = cnt_inc;
					done_d           = 1'b1;
					result_d.pattern_index  = idx_q;
					result_d.pattern_column = rd_entry.column;
					result_d.pattern_sites  = cnt_inc;
				end else if (last) begin
					done_d = 1'b1;
					if (total_q == TOTAL_FULL) begin
						result_d.table_full = 1'b1;
					end else begin
						// append after the last stored pattern
						mem.we           = 1'b1;
						mem.waddr        = total_q[IDX_W-1:0];
						mem.wdata.column = col_q;
						mem.wdata.sites  = COUNT_W'(1);
						total_d          = total_q + TOTAL_W'(1);
						result_d.pattern_index  = total_q[IDX_W-1:0];
						result_d.is_new         = 1'b1;
						result_d.pattern_column = col_q;
						result_d.pattern_sites  = COUNT_W'(1);
						result_d.total_patterns = total_q + TOTAL_W'(1);
					end
				end else begin
					mem.re    = 1'b1;
					mem.raddr = idx_q + IDX_W'(1);
					idx_d     = idx_q + IDX_W'(1);
				end
			end
			ST_READ: begin
				done_d = 1'b1;
				result_d.pattern_index  = idx_q;
				result_d.pattern_column = rd_entry.column;
				result_d.pattern_sites  = rd_entry.sites;
			end
			default: begin
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			total_q <= total_d;
			done_q  <= done_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		col_q    <= col_d;
		idx_q    <= idx_d;
		result_q <= result_d;
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

[rtl/spdc_checker.sv]
// Port-level checks of the site pattern dedup core, bound to the top level.
// Uses spdc_pkg and site_pattern_dedup_counter_core_assert.svh.
`default_nettype none

`include "site_pattern_dedup_counter_core_assert.svh"

module spdc_checker import spdc_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              done,
	input wire rsp_t              result
);

	// An accepted command either answers next cycle or keeps the core busy
	`SPDC_ASSERT_NEXT(a_accept_progress, clk, arst_n, start && !busy, done || busy)

	// A result is never both a new entry and a table overflow
	`SPDC_ASSERT_IMPLY(a_new_not_full, clk, arst_n, done, !(result.is_new && result.table_full))

	// A new entry starts with one site
	`SPDC_ASSERT_IMPLY(a_new_one_site, clk, arst_n, done && result.is_new,
		result.pattern_sites == COUNT_W'(1))

	// Overflow only with every entry taken
	`SPDC_ASSERT_IMPLY(a_full_total, clk, arst_n, done && result.table_full,
		result.total_patterns == TOTAL_FULL)

endmodule

bind site_pattern_dedup_counter_core spdc_checker u_spdc_checker (.*);

`default_nettype wire
